// ===== hdl/ppfa_pkg.sv =====
// Package for the page frame allocator: sizes, register indexes, status codes
// and the item types of both channels.
// No dependencies.
package ppfa_pkg;

	// Frame count must be a multiple of the bitmap word width
	localparam int NUM_FRAMES = 1024;
	localparam int PAGE_SHIFT = 12;
	localparam int WORD_W     = 32;
	localparam int NUM_WORDS  = NUM_FRAMES / WORD_W;
	localparam int WADDR_W    = $clog2(NUM_WORDS);
	localparam int BIT_W      = $clog2(WORD_W);
	localparam int FIDX_W     = $clog2(NUM_FRAMES);
	localparam int ACNT_W     = FIDX_W + 1;

	localparam int BASE_W  = 29;
	localparam int COUNT_W = 11;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 29;

	localparam logic [COUNT_W-1:0] PAGE_COUNT_RST = COUNT_W'(1024);
	localparam logic [31:0]        KSEG_BASE      = 32'h8000_0000;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FRAME_PADDR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT        = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOMEM    = 2'd1;
	localparam logic [1:0] ST_NOTALLOC = 2'd2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef struct packed {
		logic        op;
		logic [31:0] free_vaddr;
	} ppfa_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] page_vaddr;
	} ppfa_out_t;

endpackage

// ===== hdl/ppfa_bitmap_ram.sv =====
// Used-bit bitmap store: one word of WORD_W frame bits per address, registered
// read, per-word valid bits that stand in for the reset image.
// Depends on ppfa_pkg.
module ppfa_bitmap_ram
	import ppfa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [WADDR_W-1:0] rd_addr,
	output logic [WORD_W-1:0]  rd_data,
	input  logic               wr_en,
	input  logic [WADDR_W-1:0] wr_addr,
	input  logic [WORD_W-1:0]  wr_data
);

	logic [WORD_W-1:0]    mem [NUM_WORDS];
	logic [NUM_WORDS-1:0] vld_q;
	logic [WORD_W-1:0]    rd_word_s1;
	logic                 rd_vld_s1;
	logic                 rd_zero_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_word_s1 <= mem[rd_addr];
		rd_zero_s1 <= (rd_addr == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_s1 <= vld_q[rd_addr];
		end
	end

	// An unwritten word reads as its reset image: frame 0 reserved, rest free
	assign rd_data = rd_vld_s1 ? rd_word_s1 : WORD_W'(rd_zero_s1);

endmodule

// ===== hdl/physical_page_frame_allocator_core.sv =====
// First-fit page frame allocator. An allocate item scans the used-bit bitmap
// one 32-frame word per cycle from frame 0 upward and takes the lowest free
// frame below the page count. Word 0 is read at the acceptance edge, so the
// first word is ready as the scan begins; the single read port of the bitmap
// memory sets the scan rate. A free item does an address check with the word
// read, then a bit test and write-back; a bad address finishes after the check
// alone. One item is in flight at a time, and the block passes through idle
// between items, so it cannot take a new item before the last one is finished.
// A finished result waits in the output register while the next item is
// accepted; a stalled output holds the item after that in its last cycle. The
// bitmap comes out of reset ready, with no clearing pass. Configuration writes
// are always taken.
module physical_page_frame_allocator_core
	import ppfa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  ppfa_in_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output ppfa_out_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FCHK, S_FRD} state_t;

	state_t             state_q;
	logic [BASE_W-1:0]  first_frame_q;
	logic [COUNT_W-1:0] page_count_q;
	logic [31:0]        va_q;
	logic [FIDX_W-1:0]  fidx_q;
	logic [WADDR_W-1:0] word_q;
	logic               out_valid_q;
	ppfa_out_t          out_data_q;

	logic [WADDR_W-1:0] rd_addr;
	logic [WORD_W-1:0]  rd_data;
	logic               wr_en;
	logic [WADDR_W-1:0] wr_addr;
	logic [WORD_W-1:0]  wr_data;

	logic [31:0]         base_va;
	logic [ACNT_W-1:0]   eff_cnt;
	logic [WADDR_W:0]    full_words;
	logic [BIT_W-1:0]    rem_bits;
	logic [WADDR_W:0]    wx;
	logic [WADDR_W:0]    wn;
	logic [WORD_W-1:0]   mask;
	logic [WORD_W-1:0]   free_bits;
	logic [WORD_W-1:0]   lowest;
	logic [BIT_W-1:0]    low_idx;
	logic                found;
	logic                next_has;
	logic [31:0]         off;
	logic [31:PAGE_SHIFT] off_idx;
	logic                free_ok;
	logic                bit_set;
	logic                out_free;
	logic                done;
	logic [1:0]          res_status;
	logic [31:0]         res_vaddr;
	logic                in_fire;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign base_va = KSEG_BASE + {3'b000, first_frame_q[BASE_W-1:PAGE_SHIFT],
		{PAGE_SHIFT{1'b0}}};

	always_comb begin
		if (32'(page_count_q) >= 32'(NUM_FRAMES)) begin
			eff_cnt = ACNT_W'(NUM_FRAMES);
		end else begin
			eff_cnt = ACNT_W'(page_count_q);
		end
	end

	assign full_words = eff_cnt[ACNT_W-1:BIT_W];
	assign rem_bits   = eff_cnt[BIT_W-1:0];
	assign wx         = {1'b0, word_q};
	assign wn         = wx + 1'b1;
	assign next_has   = (wn < full_words) || ((wn == full_words) && (rem_bits != '0));

	// Frames of the scanned word that lie below the page count
	always_comb begin
		if (wx < full_words) begin
			mask = '1;
		end else if (wx == full_words) begin
			mask = (WORD_W'(1) << rem_bits) - WORD_W'(1);
		end else begin
			mask = '0;
		end
	end

	assign free_bits = ~rd_data & mask;
	assign lowest    = free_bits & (~free_bits + WORD_W'(1));
	assign found     = (free_bits != '0);

	always_comb begin
		low_idx = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (lowest[i]) begin
				low_idx = low_idx | BIT_W'(i);
			end
		end
	end

	assign off     = va_q - base_va;
	assign off_idx = off[31:PAGE_SHIFT];
	assign free_ok = (off[PAGE_SHIFT-1:0] == '0) && (32'(off_idx) < 32'(eff_cnt))
		&& (off_idx != '0);
	assign bit_set = rd_data[fidx_q[BIT_W-1:0]];

	// Result, bitmap write-back and read address for the current state
	always_comb begin
		done       = 1'b0;
		res_status = ST_OK;
		res_vaddr  = '0;
		wr_en      = 1'b0;
		wr_addr    = word_q;
		wr_data    = rd_data;
		rd_addr    = '0;
		unique case (state_q)
			S_IDLE: begin
				rd_addr = '0;
			end
			S_SCAN: begin
				if (found || !next_has) begin
					done    = out_free;
					rd_addr = word_q;
					if (found) begin
						res_vaddr = base_va + (32'({word_q, low_idx}) << PAGE_SHIFT);
						wr_en     = out_free;
						wr_data   = rd_data | lowest;
					end else begin
						res_status = ST_NOMEM;
					end
				end else begin
					rd_addr = word_q + 1'b1;
				end
			end
			S_FCHK: begin
				rd_addr = off[PAGE_SHIFT+FIDX_W-1:PAGE_SHIFT+BIT_W];
				if (!free_ok) begin
					done       = out_free;
					res_status = ST_NOTALLOC;
				end
			end
			S_FRD: begin
				rd_addr = fidx_q[FIDX_W-1:BIT_W];
				wr_addr = fidx_q[FIDX_W-1:BIT_W];
				wr_data = rd_data & ~(WORD_W'(1) << fidx_q[BIT_W-1:0]);
				done    = out_free;
				if (bit_set) begin
					wr_en = out_free;
				end else begin
					res_status = ST_NOTALLOC;
				end
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid_q   <= 1'b0;
			out_data_q    <= '0;
			first_frame_q <= '0;
			page_count_q  <= PAGE_COUNT_RST;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_FIRST_FRAME_PADDR: first_frame_q <= cfg_data[BASE_W-1:0];
					CFG_PAGE_COUNT:        page_count_q  <= cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			out_valid_q <= (out_valid_q && out_stall) || done;
			if (done) begin
				out_data_q.status     <= res_status;
				out_data_q.page_vaddr <= res_vaddr;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= (in_data.op == OP_FREE) ? S_FCHK : S_SCAN;
					end
				end
				S_SCAN: begin
					if (done) begin
						state_q <= S_IDLE;
					end
				end
				S_FCHK: begin
					if (done) begin
						state_q <= S_IDLE;
					end else if (free_ok) begin
						state_q <= S_FRD;
					end
				end
				S_FRD: begin
					if (done) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			va_q   <= in_data.free_vaddr;
			word_q <= '0;
		end else if (state_q == S_SCAN && !found && next_has) begin
			word_q <= word_q + 1'b1;
		end
		if (state_q == S_FCHK) begin
			fidx_q <= off[PAGE_SHIFT+FIDX_W-1:PAGE_SHIFT];
		end
	end

	ppfa_bitmap_ram u_bitmap (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// Frame 0 stays reserved in every write-back
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && (wr_addr == '0) |-> wr_data[0])
		else $error("frame 0 released");

	// A failed request never carries an address
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status != ST_OK) |-> (out_data.page_vaddr == '0))
		else $error("address on failed request");

	// Every bitmap update finishes the item and loads a result
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (state_q == S_IDLE) && out_valid_q)
		else $error("write-back without result");

	// A finished item always finds the output register free
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(out_valid_q && out_stall))
		else $error("result overwrote pending item");

endmodule

// ===== verif/physical_page_frame_allocator_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the first-fit page frame allocator: queued
// allocate/free items, a bitmap predictor and a result checker.
// Depends on ppfa_pkg and physical_page_frame_allocator_core.
module physical_page_frame_allocator_core_tb
	import ppfa_pkg::*;
();

	localparam int SETTLE_CYCLES = 40;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	ppfa_in_t              in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	ppfa_out_t             out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor copy of the block's state and registers
	bit                 frames_taken [NUM_FRAMES];
	logic [BASE_W-1:0]  base_paddr;
	logic [COUNT_W-1:0] managed_pages;

	ppfa_in_t  request_queue [$];
	ppfa_out_t pending_outcomes [$];
	ppfa_out_t due_outcome;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        mismatch_count = 0;
	int        alloc_hint = 0;

	physical_page_frame_allocator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int frame_limit();
		return (int'(managed_pages) < NUM_FRAMES) ? int'(managed_pages) : NUM_FRAMES;
	endfunction

	function automatic logic [31:0] frame_va(int idx);
		return KSEG_BASE + {base_paddr[BASE_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}}
			+ (32'(idx) << PAGE_SHIFT);
	endfunction

	// Update the bitmap for one item and return the result it should produce
	function automatic ppfa_out_t apply_request(ppfa_in_t req);
		ppfa_out_t   res;
		logic [31:0] off;
		logic [31:0] idx;
		int          lim;
		lim = frame_limit();
		res.page_vaddr = '0;
		if (req.op == OP_ALLOC) begin
			res.status = ST_NOMEM;
			for (int i = 0; i < lim; i++) begin
				if (!frames_taken[i]) begin
					frames_taken[i] = 1'b1;
					res.status = ST_OK;
					res.page_vaddr = frame_va(i);
					break;
				end
			end
		end else begin
			res.status = ST_NOTALLOC;
			off = req.free_vaddr - frame_va(0);
			idx = off >> PAGE_SHIFT;
			if (off[PAGE_SHIFT-1:0] == '0 && idx < 32'(lim) && idx != 0
					&& frames_taken[idx]) begin
				frames_taken[idx] = 1'b0;
				res.status = ST_OK;
			end
		end
		return res;
	endfunction

	// Driver: predict on acceptance, then present the next item or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && !in_stall)
				pending_outcomes.push_back(apply_request(in_data));
			if (!in_valid || !in_stall) begin
				if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= request_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_outcomes.size() == 0) begin
					$display("%0t: unexpected result: status %0d vaddr %h", $time,
						out_data.status, out_data.page_vaddr);
					mismatch_count++;
				end else begin
					due_outcome = pending_outcomes.pop_front();
					if (out_data.status !== due_outcome.status) begin
						$display("%0t: status mismatch: expected %0d, actual %0d", $time,
							due_outcome.status, out_data.status);
						mismatch_count++;
					end
					if (out_data.page_vaddr !== due_outcome.page_vaddr) begin
						$display("%0t: page_vaddr mismatch: expected %h, actual %h", $time,
							due_outcome.page_vaddr, out_data.page_vaddr);
						mismatch_count++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic queue_item(logic op, logic [31:0] va);
		ppfa_in_t req;
		req.op = op;
		req.free_vaddr = va;
		request_queue.push_back(req);
	endtask

	task automatic wait_quiet();
		while (request_queue.size() != 0 || in_valid || pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_FIRST_FRAME_PADDR)
			base_paddr = data[BASE_W-1:0];
		else
			managed_pages = data[COUNT_W-1:0];
	endtask

	task automatic set_config(logic [BASE_W-1:0] base, logic [COUNT_W-1:0] count);
		wait_quiet();
		cfg_write(CFG_FIRST_FRAME_PADDR, CFG_DATA_W'(base));
		cfg_write(CFG_PAGE_COUNT, CFG_DATA_W'(count));
	endtask

	// Mostly allocates and frees near the used region, plus unaligned and wild frees
	task automatic queue_mix(int n);
		int          span;
		int          pick;
		logic [31:0] va;
		repeat (n) begin
			if ($urandom_range(99) < 55) begin
				queue_item(OP_ALLOC, $urandom);
				alloc_hint++;
			end else begin
				span = (alloc_hint + 2 < frame_limit() + 1) ? alloc_hint + 2 : frame_limit() + 1;
				va = frame_va($urandom_range(0, span));
				pick = $urandom_range(9);
				if (pick == 0)
					va = $urandom;
				else if (pick == 1)
					va = va + $urandom_range(1, (1 << PAGE_SHIFT) - 1);
				queue_item(OP_FREE, va);
			end
		end
	endtask

	initial begin
		base_paddr = '0;
		managed_pages = PAGE_COUNT_RST;
		foreach (frames_taken[i])
			frames_taken[i] = (i == 0);
		send_idle_pct = 20;
		recv_stall_pct = 60;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset settings
		queue_item(OP_ALLOC, 32'hFFFF_FFFF);
		queue_item(OP_ALLOC, 32'h0000_0000);
		queue_item(OP_ALLOC, 32'h8000_2000);
		queue_item(OP_FREE, frame_va(2));
		queue_item(OP_FREE, frame_va(2));
		queue_item(OP_FREE, frame_va(0));
		queue_item(OP_FREE, frame_va(1) + 32'h4);
		queue_item(OP_FREE, frame_va(0) - 32'h1000);
		queue_item(OP_FREE, frame_va(NUM_FRAMES));
		queue_item(OP_FREE, 32'hFFFF_FFFF);
		queue_item(OP_FREE, 32'h0000_0000);
		queue_item(OP_ALLOC, 32'h1234_5678);
		queue_item(OP_FREE, frame_va(3));
		// shrunk count keeps frames above it in use
		set_config(29'h0, 11'd2);
		queue_item(OP_ALLOC, 32'h0);
		queue_item(OP_FREE, frame_va(2));
		set_config(29'h0, 11'd0);
		queue_item(OP_ALLOC, 32'h0);
		queue_item(OP_FREE, frame_va(1));
		// unaligned base, count above the frame total
		set_config(29'h1FFF_FFFF, 11'd2047);
		queue_item(OP_ALLOC, 32'h0);
		queue_item(OP_FREE, frame_va(3));
		alloc_hint = 4;

		queue_mix(100);
		set_config(29'h1FFF_F000, 11'd1024);
		queue_mix(100);
		send_idle_pct = 60;
		recv_stall_pct = 20;
		set_config(29'($urandom) & ~29'hFFF, 11'd3);
		queue_mix(60);
		set_config(29'($urandom), 11'($urandom_range(4, 48)));
		queue_mix(120);
		set_config(29'h0, 11'd1);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		queue_mix(40);
		set_config(29'($urandom), 11'($urandom_range(0, 2047)));
		queue_mix(180);

		wait_quiet();
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
